@@ rtl/sbr_pkg.sv @@
package sbr_pkg;

	// defaults for the top level parameters
	localparam int NUM_CHANNELS_DEF  = 16;
	localparam int CHANNEL_WIDTH_DEF = 11;
	localparam int FRAME_LENGTH_DEF  = 25;

	// fixed field widths
	localparam int BYTE_W  = 8;
	localparam int GAP_W   = 16;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 4;
	localparam int VALUE_W = 11;
	localparam int POS_W   = 5;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

	localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 16'h1690;
	localparam logic             CHECK_END_RESET = 1'b0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_END = 1'd1;

	// frame queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_CHANNEL  = 2'd0,
		KIND_TIMING   = 2'd1,
		KIND_END_BYTE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic [GAP_W-1:0]  gap_ticks;
		logic              overrun;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   channel_index;
		logic [VALUE_W-1:0] channel_value;
		logic               last;
	} out_item_t;

	// number of payload bytes that hold all channels
	function automatic int payload_bytes(input int num_ch, input int ch_w);
		return (num_ch * ch_w + 7) / 8;
	endfunction

endpackage

@@ rtl/sbr_queue.sv @@
module sbr_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid,
	output logic             full
);
	import sbr_pkg::*;

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/sbr_front.sv @@
module sbr_front #(
	parameter int NUM_CHANNELS  = sbr_pkg::NUM_CHANNELS_DEF,
	parameter int CHANNEL_WIDTH = sbr_pkg::CHANNEL_WIDTH_DEF,
	parameter int FRAME_LENGTH  = sbr_pkg::FRAME_LENGTH_DEF,
	parameter int JOB_W         = sbr_pkg::KIND_W
		+ 8 * sbr_pkg::payload_bytes(NUM_CHANNELS, CHANNEL_WIDTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  sbr_pkg::in_item_t            item,
	input  logic [sbr_pkg::GAP_W-1:0]    gap_limit,
	input  logic                         check_end,
	output logic                         job_push,
	output logic [JOB_W-1:0]             job_data
);
	import sbr_pkg::*;

	localparam int PAYLOAD_BYTES = payload_bytes(NUM_CHANNELS, CHANNEL_WIDTH);
	localparam int PAY_W         = 8 * PAYLOAD_BYTES;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

	logic              in_frame_q;
	logic              gap_failed_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] payload_q [PAYLOAD_BYTES];
	logic [PAY_W-1:0]  payload_next;
	logic              fail_now;
	logic              fail_any;
	logic              frame_end;
	kind_t             job_kind;

	assign fail_now  = (item.gap_ticks > gap_limit) || item.overrun;
	assign fail_any  = gap_failed_q || fail_now;
	assign frame_end = in_frame_q && (pos_q == LAST_POS);

	// payload with the byte in flight merged, so a short frame sees its last byte
	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (in_frame_q && (pos_q == POS_W'(i + 1))) begin
				payload_next[i*8 +: 8] = item.rx_byte;
			end else begin
				payload_next[i*8 +: 8] = payload_q[i];
			end
		end
	end

	always_comb begin
		priority if (fail_any) begin
			job_kind = KIND_TIMING;
		end else if (check_end && (item.rx_byte != END_BYTE)) begin
			job_kind = KIND_END_BYTE;
		end else begin
			job_kind = KIND_CHANNEL;
		end
	end

	assign job_push = accept && frame_end;
	assign job_data = {job_kind, payload_next};

	always_ff @(posedge clk) begin
		if (accept && in_frame_q) begin
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				payload_q[i] <= payload_next[i*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			gap_failed_q <= 1'b0;
			pos_q        <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (item.rx_byte == START_BYTE) begin
					in_frame_q   <= 1'b1;
					pos_q        <= POS_W'(1);
					gap_failed_q <= 1'b0;
				end
			end else if (frame_end) begin
				in_frame_q   <= 1'b0;
				pos_q        <= '0;
				gap_failed_q <= 1'b0;
			end else begin
				pos_q        <= pos_q + 1'b1;
				gap_failed_q <= fail_any;
			end
		end
	end

endmodule

@@ rtl/sbr_back.sv @@
module sbr_back #(
	parameter int NUM_CHANNELS  = sbr_pkg::NUM_CHANNELS_DEF,
	parameter int CHANNEL_WIDTH = sbr_pkg::CHANNEL_WIDTH_DEF,
	parameter int JOB_W         = sbr_pkg::KIND_W
		+ 8 * sbr_pkg::payload_bytes(NUM_CHANNELS, CHANNEL_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  logic [JOB_W-1:0]    job_data,
	output logic                job_pop,
	output sbr_pkg::out_item_t  result,
	output logic                empty,
	input  logic                pop
);
	import sbr_pkg::*;

	localparam int PAY_W = JOB_W - KIND_W;
	localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

	kind_t                        job_kind;
	logic [PAY_W-1:0]             payload;
	logic [IDX_W-1:0]             ch_q;
	logic [CHANNEL_WIDTH-1:0]     chan;
	logic [VALUE_W+CHANNEL_WIDTH-1:0] chan_ext;
	logic                         advance;
	logic                         emit;
	logic                         last_ch;
	out_item_t                    next_result;
	out_item_t                    result_q;
	logic                         valid_q;

	assign job_kind = kind_t'(job_data[JOB_W-1 -: KIND_W]);
	assign payload  = job_data[PAY_W-1:0];

	// channel window, little-endian bit order
	assign chan     = payload[int'(ch_q) * CHANNEL_WIDTH +: CHANNEL_WIDTH];
	assign chan_ext = {{VALUE_W{1'b0}}, chan};
	assign last_ch  = (ch_q == LAST_CH);

	assign advance = !valid_q || pop;
	assign emit    = job_valid && advance;

	always_comb begin
		if (job_kind == KIND_CHANNEL) begin
			next_result.kind          = KIND_CHANNEL;
			next_result.channel_index = ch_q;
			next_result.channel_value = chan_ext[VALUE_W-1:0];
			next_result.last          = last_ch;
			job_pop                   = emit && last_ch;
		end else begin
			next_result.kind          = job_kind;
			next_result.channel_index = '0;
			next_result.channel_value = '0;
			next_result.last          = 1'b1;
			job_pop                   = emit;
		end
	end

	assign result = result_q;
	assign empty  = !valid_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= next_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ch_q    <= '0;
		end else begin
			if (advance) begin
				valid_q <= emit;
			end
			if (emit && (job_kind == KIND_CHANNEL)) begin
				ch_q <= last_ch ? '0 : ch_q + 1'b1;
			end
		end
	end

endmodule

@@ rtl/sbus_frame_receiver.sv @@
// channel   | direction | handshake            | payload
// bytes     | in        | push / full          | item   (rx_byte, gap_ticks, overrun)
// results   | out       | pop / empty          | result (kind, channel_index, channel_value, last)
// config    | in        | cfg_wr, cfg_index    | cfg_data (gap_limit, check_end_byte)
//
// a byte transfer is taken every cycle unless full; the last byte of a frame hands one job
// to a two-entry frame queue, and full is high only while that queue holds two frames
// the back end drains a good frame as one result per channel and a reject as a single result;
// a result is registered from the job at the head of the queue once the result slot is free
// reset clears the hunt state, the queue and the result valid flag and loads the register
// defaults; the payload store is not cleared; a withheld pop can stall the back end and bytes
module sbus_frame_receiver #(
	parameter int NUM_CHANNELS  = sbr_pkg::NUM_CHANNELS_DEF,
	parameter int CHANNEL_WIDTH = sbr_pkg::CHANNEL_WIDTH_DEF,
	parameter int FRAME_LENGTH  = sbr_pkg::FRAME_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte side
	input  logic                          push,
	output logic                          full,
	input  sbr_pkg::in_item_t             item,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output sbr_pkg::out_item_t            result,
	// configuration
	input  logic                          cfg_wr,
	input  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbr_pkg::CFG_W-1:0]     cfg_data
);
	import sbr_pkg::*;

	localparam int PAYLOAD_BYTES = payload_bytes(NUM_CHANNELS, CHANNEL_WIDTH);
	localparam int JOB_W         = KIND_W + 8 * PAYLOAD_BYTES;

	logic [GAP_W-1:0] gap_limit_q;
	logic             check_end_q;
	logic             accept;
	logic             job_push;
	logic [JOB_W-1:0] job_wdata;
	logic [JOB_W-1:0] job_rdata;
	logic             job_valid;
	logic             job_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RESET;
			check_end_q <= CHECK_END_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_GAP_LIMIT: gap_limit_q <= cfg_data;
				REG_CHECK_END: check_end_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// byte transfer
	assign accept = push && !full;

	// front end: hunt, track position, gather payload, classify the frame
	sbr_front #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.CHANNEL_WIDTH (CHANNEL_WIDTH),
		.FRAME_LENGTH  (FRAME_LENGTH),
		.JOB_W         (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.gap_limit (gap_limit_q),
		.check_end (check_end_q),
		.job_push  (job_push),
		.job_data  (job_wdata)
	);

	// finished frames waiting for the back end
	sbr_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wdata),
		.rd_en   (job_pop),
		.rd_data (job_rdata),
		.valid   (job_valid),
		.full    (full)
	);

	// back end: unpack channels or emit the reject, one result per cycle while results are popped
	sbr_back #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.CHANNEL_WIDTH (CHANNEL_WIDTH),
		.JOB_W         (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// back end never retires a frame the queue does not hold
	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("frame retired from empty queue");

	// the last channel result carries the top channel index
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_CHANNEL && result.last)
			|-> (result.channel_index == IDX_W'(NUM_CHANNELS - 1)))
		else $error("last flag on wrong channel");

	// a reject is a single result with zero payload
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_CHANNEL)
			|-> (result.last && result.channel_index == '0 && result.channel_value == '0))
		else $error("malformed reject result");

	// a frame job is only pushed on a byte transfer
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> accept)
		else $error("frame job without byte transfer");

endmodule
